[sv/circular_trajectory_generator_unit_assert.svh]
// Assertion macros shared by the trajectory generator modules.
`ifndef CIRCULAR_TRAJECTORY_GENERATOR_UNIT_ASSERT_SVH
`define CIRCULAR_TRAJECTORY_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CTG_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define CTG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[sv/ctg_pkg.sv]
// Shared types, constants and tables for the circular trajectory generator.
package ctg_pkg;

  localparam int CORDIC_STEPS_DEF = 24;

  localparam logic [1:0] REG_RADIUS      = 2'd0;
  localparam logic [1:0] REG_SPEED_LIMIT = 2'd1;
  localparam logic [1:0] REG_ACCEL       = 2'd2;
  localparam logic [1:0] REG_RUN_TIME    = 2'd3;

  localparam int DIV_W = 57;
  localparam int MUL_W = 64;
  localparam int XY_W  = 42;
  localparam int Z_W   = 34;

  localparam logic [25:0] TURN_CONST   = 26'd44798134;
  localparam logic [30:0] GAIN_INV     = 31'd1304065748;
  localparam logic [31:0] USEC_PER_SEC = 32'd1000000;
  localparam logic [31:0] HALF_SEC_US  = 32'd500000;

  typedef struct packed {
    logic             start;
    logic [MUL_W-1:0] mcand;
    logic [31:0]      mplier;
    logic [5:0]       nbits;
  } mul_req_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [31:0]      divisor;
  } div_req_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [29:0] atan_turns(input logic [4:0] i);
    logic [29:0] r;
    begin
      case (i)
        5'd0:  r = 30'h20000000;
        5'd1:  r = 30'h12E4051D;
        5'd2:  r = 30'h09FB385B;
        5'd3:  r = 30'h051111D4;
        5'd4:  r = 30'h028B0D43;
        5'd5:  r = 30'h0145D7E1;
        5'd6:  r = 30'h00A2F61E;
        5'd7:  r = 30'h00517C55;
        5'd8:  r = 30'h0028BE53;
        5'd9:  r = 30'h00145F2E;
        5'd10: r = 30'h000A2F98;
        5'd11: r = 30'h000517CC;
        5'd12: r = 30'h00028BE6;
        5'd13: r = 30'h000145F3;
        5'd14: r = 30'h0000A2F9;
        5'd15: r = 30'h0000517C;
        5'd16: r = 30'h000028BE;
        5'd17: r = 30'h0000145F;
        5'd18: r = 30'h00000A2F;
        5'd19: r = 30'h00000517;
        5'd20: r = 30'h0000028B;
        5'd21: r = 30'h00000145;
        5'd22: r = 30'h000000A2;
        5'd23: r = 30'h00000051;
        5'd24: r = 30'h00000028;
        5'd25: r = 30'h00000014;
        5'd26: r = 30'h0000000A;
        5'd27: r = 30'h00000005;
        5'd28: r = 30'h00000002;
        5'd29: r = 30'h00000001;
        default: r = 30'h0;
      endcase
      return r;
    end
  endfunction

  function automatic logic [31:0] sat32(input logic signed [35:0] v);
    logic [31:0] r;
    begin
      if (v > 36'sh07FFFFFFF) r = 32'h7FFFFFFF;
      else if (v < -36'sh080000000) r = 32'h80000000;
      else r = v[31:0];
      return r;
    end
  endfunction

endpackage

[sv/ctg_mul.sv]
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
`include "circular_trajectory_generator_unit_assert.svh"
module ctg_mul (
  input  logic                    clk,
  input  logic                    rst,
  input  ctg_pkg::mul_req_t       req,
  output logic                    done,
  output logic [ctg_pkg::MUL_W-1:0] prod
);
  import ctg_pkg::*;

  logic [MUL_W-1:0] acc;
  logic [MUL_W-1:0] mc;
  logic [31:0]      mp;
  logic [5:0]       cnt;
  logic             busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !req.start && busy && (cnt == 6'd1);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.nbits;
        acc  <= '0;
        mc   <= req.mcand;
        mp   <= req.mplier;
      end else if (busy) begin
        if (mp[0]) acc <= acc + mc;
        mc  <= {mc[MUL_W-2:0], 1'b0};
        mp  <= {1'b0, mp[31:1]};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign prod = acc;

  `CTG_ASSERT_NEXT(a_mul_done_pulse, done, !done)
  `CTG_ASSERT_SAME(a_mul_done_idle, done, !busy)
endmodule

[sv/ctg_div.sv]
// Restoring bit-serial divider, one quotient bit per cycle.
`include "circular_trajectory_generator_unit_assert.svh"
module ctg_div (
  input  logic                      clk,
  input  logic                      rst,
  input  ctg_pkg::div_req_t         req,
  output logic                      done,
  output logic [ctg_pkg::DIV_W-1:0] quo,
  output logic [31:0]               rem
);
  import ctg_pkg::*;

  logic [31:0] dvsr;
  logic [5:0]  cnt;
  logic        busy;
  logic [32:0] trial;

  assign trial = {rem, quo[DIV_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !req.start && busy && (cnt == 6'd1);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 6'(DIV_W);
        rem  <= '0;
        quo  <= req.dividend;
        dvsr <= req.divisor;
      end else if (busy) begin
        if (trial >= {1'b0, dvsr}) begin
          rem <= 32'(trial - {1'b0, dvsr});
          quo <= {quo[DIV_W-2:0], 1'b1};
        end else begin
          rem <= trial[31:0];
          quo <= {quo[DIV_W-2:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end

  `CTG_ASSERT_SAME(a_div_rem_small, done && dvsr != 32'd0, rem < dvsr)
  `CTG_ASSERT_NEXT(a_div_done_pulse, done, !done)
endmodule

[sv/ctg_cordic.sv]
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
`include "circular_trajectory_generator_unit_assert.svh"
module ctg_cordic #(
  parameter int STEPS = ctg_pkg::CORDIC_STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic signed [ctg_pkg::XY_W-1:0] x0,
  input  logic signed [ctg_pkg::Z_W-1:0]  z0,
  output logic                            done,
  output logic signed [ctg_pkg::XY_W-1:0] x,
  output logic signed [ctg_pkg::XY_W-1:0] y
);
  import ctg_pkg::*;

  localparam int CW = $clog2(STEPS) + 1;

  logic signed [Z_W-1:0]  z;
  logic [CW-1:0]          i;
  logic                   busy;
  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;
  logic signed [Z_W-1:0]  at;

  assign dx = y >>> i[4:0];
  assign dy = x >>> i[4:0];
  assign at = signed'({{(Z_W-30){1'b0}}, atan_turns(i[4:0])});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      i    <= '0;
    end else begin
      done <= !start && busy && (i == CW'(STEPS - 1));
      if (start) begin
        busy <= 1'b1;
        i    <= '0;
        x    <= x0;
        y    <= '0;
        z    <= z0;
      end else if (busy) begin
        if (!z[Z_W-1]) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - at;
        end else begin
          x <= x + dx;
          y <= y - dy;
          z <= z + at;
        end
        i <= i + 1'b1;
        if (i == CW'(STEPS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  `CTG_ASSERT_NEXT(a_cordic_done_pulse, done, !done && !busy)
endmodule

[sv/circular_trajectory_generator_unit.sv]
// Circular trajectory generator top level: control sequencer, registers and ports.
// One tick in gives one pose out. Each tick runs through a bit-serial multiplier
// (five products when the radius is nonzero, two otherwise), a bit-serial divider
// (three times when the radius is nonzero, once otherwise) and an iterative CORDIC,
// with registered start and done handoffs around each unit. Only one tick is in
// flight at a time, since the serial multiplier and divider are shared; a finished
// pose waits in ST_TARGET while the previous pose is still held untaken in the
// output register. A new tick is accepted as soon as the previous pose has
// been placed in the output register, even if it is not yet taken.
`include "circular_trajectory_generator_unit_assert.svh"
module circular_trajectory_generator_unit #(
  parameter int CORDIC_STEPS = ctg_pkg::CORDIC_STEPS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [79:0]  s_tdata,   // period_us[15:0], start_x[47:16], start_y[79:48]
  output logic         m_tvalid,
  input  logic         m_tready,
  // target_x[31:0], target_y[63:32], offset_x[95:64], offset_y[127:96],
  // speed_now[158:128], finished[159]
  output logic [159:0] m_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import ctg_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_STEP_MUL, ST_STEP_DIV, ST_SPEED, ST_NUM_MUL, ST_Q_DIV,
    ST_QC_MUL, ST_RC_MUL, ST_RC_DIV, ST_GAIN_MUL, ST_CORDIC, ST_TARGET
  } state_t;

  state_t state;

  logic [30:0] radius, speed_limit, accel;
  logic [31:0] run_time_us;
  logic [31:0] elapsed_us, phase, origin_x, origin_y;
  logic [30:0] speed;
  logic [15:0] period;
  logic [31:0] step;
  logic [31:0] rreg;
  logic [47:0] qc;
  logic        flip;
  logic [31:0] ox, oy;

  mul_req_t mreq;
  div_req_t dreq;
  logic             mul_done, div_done, cor_done;
  logic [MUL_W-1:0] mul_prod;
  logic [DIV_W-1:0] div_quo;
  logic [31:0]      div_rem;
  logic             cor_start;
  logic signed [XY_W-1:0] cor_x0, cor_x, cor_y;
  logic signed [Z_W-1:0]  cor_z0;

  ctg_mul u_mul (.clk, .rst, .req(mreq), .done(mul_done), .prod(mul_prod));
  ctg_div u_div (.clk, .rst, .req(dreq), .done(div_done), .quo(div_quo), .rem(div_rem));
  ctg_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk, .rst, .start(cor_start), .x0(cor_x0), .z0(cor_z0),
    .done(cor_done), .x(cor_x), .y(cor_y)
  );

  // Configuration port.
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      REG_RADIUS:      prdata = {1'b0, radius};
      REG_SPEED_LIMIT: prdata = {1'b0, speed_limit};
      REG_ACCEL:       prdata = {1'b0, accel};
      REG_RUN_TIME:    prdata = run_time_us;
      default:         prdata = '0;
    endcase
  end

  // Tick front end.
  logic [15:0] in_period;
  logic [32:0] el_sum;
  logic [31:0] el_new;
  assign in_period = s_tdata[15:0];
  assign el_sum    = {1'b0, elapsed_us} + {17'b0, in_period};
  assign el_new    = el_sum[32] ? 32'hFFFFFFFF : el_sum[31:0];
  assign s_tready  = (state == ST_IDLE);

  // Speed ramp.
  logic signed [33:0] sp_a, sp_b, sp_new;
  logic signed [33:0] lim_s;
  assign lim_s = signed'({3'b0, speed_limit});
  always_comb begin
    sp_a = signed'({3'b0, speed});
    if (sp_a < lim_s && elapsed_us < run_time_us) sp_a = sp_a + signed'({2'b0, step});
    sp_b = sp_a;
    if (sp_b > 34'sd0 && elapsed_us > run_time_us) sp_b = sp_b - signed'({2'b0, step});
    sp_new = sp_b;
    if (sp_new < 34'sd0) sp_new = '0;
    if (sp_new > lim_s) sp_new = lim_s;
  end

  // Angle folding into the CORDIC range.
  logic signed [Z_W-1:0] ang;
  logic                  ang_flip;
  always_comb begin
    ang = signed'({{(Z_W-32){phase[31]}}, phase});
    ang_flip = 1'b0;
    if (ang > 34'sh040000000) begin
      ang = ang - 34'sh080000000;
      ang_flip = 1'b1;
    end else if (ang < -34'sh040000000) begin
      ang = ang + 34'sh080000000;
      ang_flip = 1'b1;
    end
  end

  // Rounding of CORDIC results and offsets.
  logic signed [XY_W-1:0] xr, yr;
  logic signed [35:0]     cx, sy, ox_w;
  assign xr   = (cor_x + XY_W'(128)) >>> 8;
  assign yr   = (cor_y + XY_W'(128)) >>> 8;
  assign cx   = flip ? -xr[35:0] : xr[35:0];
  assign sy   = flip ? -yr[35:0] : yr[35:0];
  assign ox_w = signed'({5'b0, radius}) - cx;

  logic signed [35:0] tx_w, ty_w;
  assign tx_w = signed'({{4{origin_x[31]}}, origin_x}) + signed'({{4{ox[31]}}, ox});
  assign ty_w = signed'({{4{origin_y[31]}}, origin_y}) + signed'({{4{oy[31]}}, oy});

  logic [47:0] inc_sum;
  assign inc_sum = qc + div_quo[47:0];

  // Start pulses for the serial units, issued on the state transitions below.
  logic mul_start_next, div_start_next, cor_start_next;
  assign mul_start_next = (state == ST_IDLE && s_tvalid) || (state == ST_SPEED) ||
                          (state == ST_Q_DIV && div_done) ||
                          (state == ST_QC_MUL && mul_done) ||
                          (state == ST_RC_DIV && div_done);
  assign div_start_next = mul_done && (state == ST_STEP_MUL || state == ST_NUM_MUL ||
                                       state == ST_RC_MUL);
  assign cor_start_next = (state == ST_GAIN_MUL) && mul_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      radius      <= 31'd838861;
      speed_limit <= 31'd1677722;
      accel       <= 31'd3355443;
      run_time_us <= 32'd3000000;
      elapsed_us  <= '0;
      speed       <= '0;
      phase       <= '0;
      origin_x    <= '0;
      origin_y    <= '0;
      m_tvalid    <= 1'b0;
      mreq.start  <= 1'b0;
      dreq.start  <= 1'b0;
      cor_start   <= 1'b0;
    end else begin
      mreq.start <= mul_start_next;
      dreq.start <= div_start_next;
      cor_start  <= cor_start_next;
      if (m_tvalid && m_tready && state != ST_TARGET) m_tvalid <= 1'b0;
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_RADIUS:      radius      <= pwdata[30:0];
          REG_SPEED_LIMIT: speed_limit <= pwdata[30:0];
          REG_ACCEL:       accel       <= pwdata[30:0];
          REG_RUN_TIME:    run_time_us <= pwdata;
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            period     <= in_period;
            elapsed_us <= el_new;
            if (el_new == 32'd0) begin
              origin_x <= s_tdata[47:16];
              origin_y <= s_tdata[79:48];
            end
            mreq.mcand  <= {33'b0, accel};
            mreq.mplier <= {16'b0, in_period};
            mreq.nbits  <= 6'd16;
            state       <= ST_STEP_MUL;
          end
        end
        ST_STEP_MUL: begin
          if (mul_done) begin
            dreq.dividend <= mul_prod[DIV_W-1:0] + {25'b0, HALF_SEC_US};
            dreq.divisor  <= USEC_PER_SEC;
            state         <= ST_STEP_DIV;
          end
        end
        ST_STEP_DIV: begin
          if (div_done) begin
            step  <= div_quo[31:0];
            state <= ST_SPEED;
          end
        end
        ST_SPEED: begin
          speed <= sp_new[30:0];
          if (radius != 31'd0) begin
            mreq.mcand  <= {33'b0, sp_new[30:0]};
            mreq.mplier <= {16'b0, period};
            mreq.nbits  <= 6'd16;
            state       <= ST_NUM_MUL;
          end else begin
            mreq.mcand  <= {33'b0, GAIN_INV};
            mreq.mplier <= {1'b0, radius};
            mreq.nbits  <= 6'd31;
            state       <= ST_GAIN_MUL;
          end
        end
        ST_NUM_MUL: begin
          if (mul_done) begin
            dreq.dividend <= mul_prod[DIV_W-1:0];
            dreq.divisor  <= {1'b0, radius};
            state         <= ST_Q_DIV;
          end
        end
        ST_Q_DIV: begin
          if (div_done) begin
            rreg        <= div_rem;
            mreq.mcand  <= {7'b0, div_quo};
            mreq.mplier <= {6'b0, TURN_CONST};
            mreq.nbits  <= 6'd26;
            state       <= ST_QC_MUL;
          end
        end
        ST_QC_MUL: begin
          if (mul_done) begin
            qc          <= mul_prod[47:0];
            mreq.mcand  <= {32'b0, rreg};
            mreq.mplier <= {6'b0, TURN_CONST};
            mreq.nbits  <= 6'd26;
            state       <= ST_RC_MUL;
          end
        end
        ST_RC_MUL: begin
          if (mul_done) begin
            dreq.dividend <= mul_prod[DIV_W-1:0];
            dreq.divisor  <= {1'b0, radius};
            state         <= ST_RC_DIV;
          end
        end
        ST_RC_DIV: begin
          if (div_done) begin
            // Only bits 47:16 of the scaled increment reach the phase.
            phase       <= phase + inc_sum[47:16];
            mreq.mcand  <= {33'b0, GAIN_INV};
            mreq.mplier <= {1'b0, radius};
            mreq.nbits  <= 6'd31;
            state       <= ST_GAIN_MUL;
          end
        end
        ST_GAIN_MUL: begin
          if (mul_done) begin
            cor_x0    <= signed'({3'b0, mul_prod[61:23]});
            cor_z0    <= ang;
            flip      <= ang_flip;
            state     <= ST_CORDIC;
          end
        end
        ST_CORDIC: begin
          if (cor_done) begin
            ox    <= sat32(ox_w);
            oy    <= sat32(sy);
            state <= ST_TARGET;
          end
        end
        ST_TARGET: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {elapsed_us >= run_time_us, speed, oy, ox,
                         sat32(ty_w), sat32(tx_w)};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `CTG_ASSERT_NEXT(a_one_tick_at_a_time, s_tvalid && s_tready, !s_tready)
  `CTG_ASSERT_SAME(a_speed_in_limit, state == ST_TARGET, speed <= speed_limit)
  `CTG_ASSERT_SAME(a_no_zero_divisor, dreq.start, dreq.divisor != 32'd0)
endmodule
